### design/df1_filt_pkg.sv
// ----------------------------------------------------------------------------
// df1_filt_pkg
// Shared types and constants of the direct form one FIR/IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package df1_filt_pkg;

  // request function codes
  typedef enum logic [1:0] {
    FUNC_FILTER = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_LOAD_A = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TAPS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAC = 2'd2;

  // filter_mode codes
  localparam logic MODE_FIR = 1'b0;
  localparam logic MODE_IIR = 1'b1;

  localparam int CoefBits = 16;
  localparam int AccW     = 32;
  localparam int FracW    = 5;

endpackage

`default_nettype wire

### design/df1_filt_if.sv
// ----------------------------------------------------------------------------
// df1_filt request and result channels
// Valid/ready channels carrying filter requests and filtered samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface df1_filt_req_if
  import df1_filt_pkg::*;
#(
  parameter int SampleBits = 16,
  parameter int IdxBits    = 6
);
  logic                         valid;
  logic                         ready;
  func_e                        func;
  logic signed [SampleBits-1:0] sample_in;
  logic        [IdxBits-1:0]    coef_index;
  logic signed [CoefBits-1:0]   coef_value;

  modport source (output valid, func, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, func, sample_in, coef_index, coef_value, output ready);
endinterface

interface df1_filt_rsp_if #(
  parameter int SampleBits = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] filtered_sample;

  modport source (output valid, filtered_sample, input ready);
  modport sink   (input valid, filtered_sample, output ready);
endinterface

`default_nettype wire

### design/direct_form_one_fir_iir_filter_top.sv
// ----------------------------------------------------------------------------
// direct_form_one_fir_iir_filter_top
// Direct form one fixed-point filter, FIR or IIR, one shared MAC for all taps.
// ----------------------------------------------------------------------------
// usage
//   in_ch carries requests: filter a sample, load one b or a coefficient,
//   or clear both sample histories. only a filter request gives a result,
//   which leaves on out_ch as filtered_sample.
//   cfg_we_i/cfg_idx_i/cfg_data_i write filter_mode, tap_count and
//   fraction_bits; write them only while the filter is idle.
// timing
//   load and clear requests leave in_ch ready after them. a filter
//   request holds in_ch off until the filter is back in idle, taps being
//   tap_count saturated at MaxTaps: one tap per cycle (none with zero taps)
//   is read from the coefficient and history memories, then come a
//   multiply stage, an accumulate stage, a drain check and the shift state,
//   which loads the result into the output register. a new filter request
//   is taken only after the shift state of the last one.
// reset
//   coefficients and histories read as zero (per-entry valid bits),
//   tap_count is 1, fraction_bits 15, FIR mode. no clearing pass is needed.
// stall
//   the result sits in an output register; a new request is taken while
//   it waits. a filter request that finishes before the old result is
//   taken holds in its last cycle until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_form_one_fir_iir_filter_top
  import df1_filt_pkg::*;
#(
  parameter int MaxTaps    = 64,
  parameter int SampleBits = 16,
  localparam int IdxW = $clog2(MaxTaps),
  localparam int TapW = $clog2(MaxTaps + 1),
  localparam int CfgW = (TapW > FracW) ? TapW : FracW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  df1_filt_req_if.sink        in_ch,
  df1_filt_rsp_if.source      out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int ProdW = CoefBits + SampleBits;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  // configuration
  logic            mode_q;
  logic [TapW-1:0] taps_q;
  logic [FracW-1:0] frac_q;

  // control
  state_e          state_q;
  logic [TapW-1:0] j_q;
  logic [IdxW-1:0] slot_q;
  logic [IdxW-1:0] head_q;
  logic            v1_q, v2_q;
  logic            out_vld_q;
  logic signed [SampleBits-1:0] out_data_q;

  // per-entry valid bits: an entry not yet written reads as zero
  logic [MaxTaps-1:0] x_vld_q, y_vld_q, b_vld_q, a_vld_q;

  // memories: history rows hold {y, x}, coefficient rows hold {a, b}
  logic [2*SampleBits-1:0] hist_mem [MaxTaps];
  logic [2*CoefBits-1:0]   coef_mem [MaxTaps];
  logic [2*SampleBits-1:0] hist_rd_q;
  logic [2*CoefBits-1:0]   coef_rd_q;
  logic x_vrd_q, y_vrd_q, b_vrd_q, a_vrd_q;
  logic j0_q;

  // datapath
  logic signed [AccW-1:0] pb_q, pa_q, acc_q;

  logic            in_fire, issue, fin_fire, idx_ok;
  logic [TapW-1:0] taps_eff;
  logic [IdxW-1:0] coef_addr, hist_addr;
  logic [1:0]      coef_we, hist_we;
  logic [IdxW-1:0] slot_prev, head_next;
  logic signed [SampleBits-1:0] x_eff, y_eff;
  logic signed [CoefBits-1:0]   b_eff, a_eff;
  logic signed [ProdW-1:0]      pb_full, pa_full;
  logic signed [AccW-1:0]       acc_sh;
  logic signed [SampleBits-1:0] y_new;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // tap counts above the table depth saturate
  assign taps_eff = (taps_q > TapW'(MaxTaps)) ? TapW'(MaxTaps) : taps_q;
  assign issue    = (state_q == ST_RUN) && (j_q < taps_eff);
  assign fin_fire = (state_q == ST_FIN) && (!out_vld_q || out_ch.ready);
  assign idx_ok   = (TapW'(in_ch.coef_index) < TapW'(MaxTaps));

  // walk backwards through the history ring; the head moves forward
  assign slot_prev = (slot_q == '0) ? IdxW'(MaxTaps - 1) : slot_q - 1'b1;
  assign head_next = (head_q == IdxW'(MaxTaps - 1)) ? '0 : head_q + 1'b1;

  // single port per memory: loads/sample write in idle, result write in the shift state, reads while running
  assign coef_addr = (state_q == ST_RUN) ? j_q[IdxW-1:0] : in_ch.coef_index;
  assign hist_addr = (state_q == ST_RUN) ? slot_q : head_q;
  assign coef_we[0] = in_fire && (in_ch.func == FUNC_LOAD_B) && idx_ok;
  assign coef_we[1] = in_fire && (in_ch.func == FUNC_LOAD_A) && idx_ok;
  assign hist_we[0] = in_fire && (in_ch.func == FUNC_FILTER);
  assign hist_we[1] = fin_fire;

  // output scaling: arithmetic shift, then wrap to sample width
  assign acc_sh = acc_q >>> frac_q;
  assign y_new  = acc_sh[SampleBits-1:0];

  // operand masking by valid bits
  assign x_eff = x_vrd_q ? hist_rd_q[SampleBits-1:0] : '0;
  assign y_eff = y_vrd_q ? hist_rd_q[2*SampleBits-1:SampleBits] : '0;
  assign b_eff = b_vrd_q ? coef_rd_q[CoefBits-1:0] : '0;
  assign a_eff = a_vrd_q ? coef_rd_q[2*CoefBits-1:CoefBits] : '0;
  assign pb_full = b_eff * x_eff;
  assign pa_full = a_eff * y_eff;

  assign out_ch.valid           = out_vld_q;
  assign out_ch.filtered_sample = out_data_q;

  always_ff @(posedge clk_i) begin
    if (hist_we[0]) hist_mem[hist_addr][SampleBits-1:0] <= in_ch.sample_in;
    if (hist_we[1]) hist_mem[hist_addr][2*SampleBits-1:SampleBits] <= y_new;
    hist_rd_q <= hist_mem[hist_addr];
  end

  always_ff @(posedge clk_i) begin
    if (coef_we[0]) coef_mem[coef_addr][CoefBits-1:0] <= in_ch.coef_value;
    if (coef_we[1]) coef_mem[coef_addr][2*CoefBits-1:CoefBits] <= in_ch.coef_value;
    coef_rd_q <= coef_mem[coef_addr];
  end

  // read-side valid bits and the multiply/accumulate stages
  always_ff @(posedge clk_i) begin
    x_vrd_q <= x_vld_q[hist_addr];
    y_vrd_q <= y_vld_q[hist_addr];
    b_vrd_q <= b_vld_q[coef_addr];
    a_vrd_q <= a_vld_q[coef_addr];
    j0_q    <= (j_q == '0);
    pb_q    <= AccW'(pb_full);
    // feedback skips the leading a[0] and is off in FIR mode
    pa_q    <= (mode_q == MODE_IIR && !j0_q) ? AccW'(pa_full) : '0;
    if (hist_we[0]) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + pb_q - pa_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_FIR;
      taps_q     <= TapW'(1);
      frac_q     <= FracW'(15);
      state_q    <= ST_IDLE;
      j_q        <= '0;
      slot_q     <= '0;
      head_q     <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      x_vld_q    <= '0;
      y_vld_q    <= '0;
      b_vld_q    <= '0;
      a_vld_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE: mode_q <= cfg_data_i[0];
          CFG_TAPS: taps_q <= cfg_data_i[TapW-1:0];
          CFG_FRAC: frac_q <= cfg_data_i[FracW-1:0];
          default: ;
        endcase
      end

      // a new result replaces the old one or fills the empty register
      out_vld_q <= fin_fire || (out_vld_q && !out_ch.ready);

      v1_q <= issue;
      v2_q <= v1_q;

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (in_ch.func)
              FUNC_FILTER: begin
                x_vld_q[head_q] <= 1'b1;
                j_q             <= '0;
                slot_q          <= head_q;
                state_q         <= ST_RUN;
              end
              FUNC_LOAD_B: if (idx_ok) b_vld_q[in_ch.coef_index] <= 1'b1;
              FUNC_LOAD_A: if (idx_ok) a_vld_q[in_ch.coef_index] <= 1'b1;
              FUNC_CLEAR: begin
                x_vld_q <= '0;
                y_vld_q <= '0;
                head_q  <= '0;
              end
            endcase
          end
        end
        ST_RUN: begin
          if (issue) begin
            j_q    <= j_q + 1'b1;
            slot_q <= slot_prev;
          end else if (!v1_q && !v2_q) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_fire) begin
            out_data_q      <= y_new;
            y_vld_q[head_q] <= 1'b1;
            head_q          <= head_next;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/df1_filt_chk.sv
// ----------------------------------------------------------------------------
// df1_filt_chk
// Port-level checks of the filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module df1_filt_chk
  import df1_filt_pkg::*;
#(
  parameter int SampleBits = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input func_e                 in_func_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [SampleBits-1:0] out_data_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  // a filter request occupies the block
  a_filter_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_func_i == FUNC_FILTER |=> !in_ready_i)
    else $error("request taken during filter run");

  // loads and clears leave the input ready in the next cycle
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_func_i != FUNC_FILTER |=> in_ready_i)
    else $error("load or clear request held the input");

  // a new result only comes out of a filter run
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without a filter run");

endmodule

bind direct_form_one_fir_iir_filter_top df1_filt_chk #(.SampleBits(SampleBits)) u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .in_func_i   (in_ch.func),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_data_i  (out_ch.filtered_sample)
);

`default_nettype wire

### tb/df1_filt_response_check.sv
// ----------------------------------------------------------------------------
// df1_filt_response_check
// Watches the request, result and register ports of the filter, keeps its
// own copy of histories, coefficient tables and registers, works out each
// filtered sample and compares it with what leaves the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module df1_filt_response_check
  import df1_filt_pkg::*;
#(
  parameter int MaxTaps    = 64,
  parameter int SampleBits = 16,
  parameter int CfgW       = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  df1_filt_req_if            req_mon,
  df1_filt_rsp_if            rsp_mon,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 mismatch_cnt_o,
  output int                 pending_o
);

  localparam int IdxW = $clog2(MaxTaps);
  localparam int TapW = $clog2(MaxTaps + 1);

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [CoefBits-1:0]   coef_t;

  logic                mode_q;
  logic [TapW-1:0]     taps_q;
  logic [FracW-1:0]    frac_q;
  sample_t             x_hist [MaxTaps];
  sample_t             y_hist [MaxTaps];
  coef_t               b_coef [MaxTaps];
  coef_t               a_coef [MaxTaps];
  logic [IdxW-1:0]     head_q;
  sample_t             filtered_q [$];
  sample_t             want;
  int                  mismatches;

  function automatic void clear_histories();
    for (int i = 0; i < MaxTaps; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    head_q = '0;
  endfunction

  // one direct form one step: numerator sum, feedback in iir mode, shift, wrap
  function automatic sample_t filter_step(sample_t x);
    int                     n;
    int                     j;
    logic [IdxW-1:0]        slot;
    logic [AccW-1:0]        acc;
    logic signed [AccW-1:0] prod;
    logic signed [AccW-1:0] shifted;
    sample_t                y;
    n = (int'(taps_q) > MaxTaps) ? MaxTaps : int'(taps_q);
    x_hist[head_q] = x;
    acc = '0;
    for (j = 0; j < n; j++) begin
      slot = head_q - IdxW'(j);
      prod = b_coef[j] * x_hist[slot];
      acc  = acc + prod;
    end
    if (mode_q == MODE_IIR) begin
      // a[0] is never used
      for (j = 1; j < n; j++) begin
        slot = head_q - IdxW'(j);
        prod = a_coef[j] * y_hist[slot];
        acc  = acc - prod;
      end
    end
    shifted = $signed(acc) >>> frac_q;
    y = shifted[SampleBits-1:0];
    y_hist[head_q] = y;
    head_q = head_q + 1'b1;
    return y;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = MODE_FIR;
      taps_q = TapW'(1);
      frac_q = FracW'(15);
      for (int i = 0; i < MaxTaps; i++) begin
        b_coef[i] = '0;
        a_coef[i] = '0;
      end
      clear_histories();
      filtered_q.delete();
      mismatches = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE: mode_q = cfg_data_i[0];
          CFG_TAPS: taps_q = cfg_data_i[TapW-1:0];
          CFG_FRAC: frac_q = cfg_data_i[FracW-1:0];
          default: ;
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected filtered_sample %0d, expected none", $time,
                   rsp_mon.filtered_sample);
          mismatches++;
        end else begin
          want = filtered_q.pop_front();
          if (rsp_mon.filtered_sample !== want) begin
            $display("%0t: filtered_sample mismatch, expected %0d actual %0d", $time,
                     want, rsp_mon.filtered_sample);
            mismatches++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        case (req_mon.func)
          FUNC_FILTER: filtered_q.push_back(filter_step(req_mon.sample_in));
          FUNC_LOAD_B: if (int'(req_mon.coef_index) < MaxTaps)
                         b_coef[req_mon.coef_index] = req_mon.coef_value;
          FUNC_LOAD_A: if (int'(req_mon.coef_index) < MaxTaps)
                         a_coef[req_mon.coef_index] = req_mon.coef_value;
          FUNC_CLEAR:  clear_histories();
          default: ;
        endcase
      end
      mismatch_cnt_o <= mismatches;
      pending_o      <= filtered_q.size();
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the direct form one FIR/IIR filter with directed corner requests
// and randomized register settings and request streams, with random gaps on
// both channels; a separate response checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import df1_filt_pkg::*;

  localparam int MaxTaps    = 64;
  localparam int SampleBits = 16;
  localparam int IdxBits    = 6;
  localparam int CfgW       = 7;

  // index past the last register, writes to it must be ignored
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  // settle wait after the last request, with margin over a full-length filter request
  localparam int DrainCycles   = 96;
  // longest quiet stretch: settle wait, register writes, one long request
  // and the longest result stall, taken many times over
  localparam int WatchdogLimit = 3000;

  localparam logic signed [15:0] SMP_MAX = 16'sh7fff;
  localparam logic signed [15:0] SMP_MIN = 16'sh8000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;
  bit                 gaps_on = 1'b1;
  int                 mismatch_cnt;
  int                 pending_cnt;
  int                 quiet_cycles;

  df1_filt_req_if #(.SampleBits(SampleBits), .IdxBits(IdxBits)) req_ch ();
  df1_filt_rsp_if #(.SampleBits(SampleBits))                    rsp_ch ();

  direct_form_one_fir_iir_filter_top #(
    .MaxTaps   (MaxTaps),
    .SampleBits(SampleBits)
  ) uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  df1_filt_response_check #(
    .MaxTaps   (MaxTaps),
    .SampleBits(SampleBits),
    .CfgW      (CfgW)
  ) resp_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // random word biased toward the extremes and small magnitudes
  function automatic logic signed [15:0] rand_word();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return 16'($signed($urandom_range(0, 32)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  // one request; valid stays high into the next request unless a gap is drawn
  task automatic send_req(input func_e f, input logic signed [15:0] smp,
                          input logic [5:0] idx, input logic signed [15:0] cv);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= f;
    req_ch.sample_in  <= smp;
    req_ch.coef_index <= idx;
    req_ch.coef_value <= cv;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // filter request, coefficient fields carry noise
  task automatic send_sample(input logic signed [15:0] smp);
    send_req(FUNC_FILTER, smp, 6'($urandom), 16'($urandom));
  endtask

  // hold the sender until every filtered sample is back; with settle set,
  // also let a trailing load or clear finish before registers change
  task automatic wait_idle(input bit settle);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    if (settle) repeat (DrainCycles) @(posedge clk);
  endtask

  // all three registers plus a stray write past the last index
  task automatic apply_config(input logic mode, input logic [6:0] taps,
                              input logic [4:0] frac);
    wait_idle(1'b1);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MODE;
    cfg_data <= CfgW'(mode);
    @(posedge clk);
    cfg_idx  <= CFG_TAPS;
    cfg_data <= CfgW'(taps);
    @(posedge clk);
    cfg_idx  <= CFG_FRAC;
    cfg_data <= CfgW'(frac);
    @(posedge clk);
    cfg_idx  <= CFG_SPARE;
    cfg_data <= CfgW'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // one setting: preload up to the first eight live coefficients, then a mostly-filter stream
  task automatic run_phase(input int n, input logic mode, input logic [6:0] taps,
                           input logic [4:0] frac);
    int               live;
    int               k;
    int               pick;
    logic [5:0]       idx;
    apply_config(mode, taps, frac);
    live = (taps == 0) ? 1 : ((taps > MaxTaps) ? MaxTaps : int'(taps));
    for (k = 0; k < live && k < 8; k++) begin
      send_req(FUNC_LOAD_B, rand_word(), 6'(k), rand_word());
      send_req(FUNC_LOAD_A, rand_word(), 6'(k), rand_word());
    end
    for (k = 0; k < n; k++) begin
      // pause mid-stream until all filtered samples are back
      if (gaps_on && k == n / 2) wait_idle(1'b0);
      pick = $urandom_range(0, 99);
      // mostly indexes inside the live taps, sometimes anywhere
      idx  = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, live - 1));
      if (pick < 82) send_sample(rand_word());
      else if (pick < 90) send_req(FUNC_LOAD_B, rand_word(), idx, rand_word());
      else if (pick < 97) send_req(FUNC_LOAD_A, rand_word(), idx, rand_word());
      else send_req(FUNC_CLEAR, rand_word(), idx, rand_word());
    end
  endtask

  // result side: ready drops in random bursts while gaps are on
  initial begin
    rsp_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  end

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no progress for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= FUNC_FILTER;
    req_ch.sample_in  <= '0;
    req_ch.coef_index <= '0;
    req_ch.coef_value <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_MODE;
    cfg_data          <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: fir, one tap, 15 fraction bits, all tables zero
    send_sample(SMP_MAX);
    // table ends and the leading a coefficient, which must have no effect
    send_req(FUNC_LOAD_B, rand_word(), 6'd0,  SMP_MIN);
    send_req(FUNC_LOAD_B, rand_word(), 6'd63, SMP_MAX);
    send_req(FUNC_LOAD_A, rand_word(), 6'd0,  16'sd12345);
    send_req(FUNC_LOAD_A, rand_word(), 6'd1,  SMP_MIN);
    send_req(FUNC_LOAD_A, rand_word(), 6'd63, SMP_MAX);
    // largest product, shifted result wraps to the negative end
    send_sample(SMP_MIN);
    send_sample(SMP_MAX);
    send_sample(-16'sd1);
    send_req(FUNC_CLEAR, rand_word(), 6'($urandom), rand_word());
    send_sample(16'sd1);

    // iir, all taps, no shift: feedback of outputs recorded while in fir
    apply_config(MODE_IIR, 7'd64, 5'd0);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(SMP_MAX);
    // zero taps gives zero output
    apply_config(MODE_IIR, 7'd0, 5'd31);
    send_sample(SMP_MIN);
    // tap count above the table size saturates, widest shift
    apply_config(MODE_FIR, 7'd127, 5'd31);
    send_sample(SMP_MIN);
    send_sample(-16'sd1);
    apply_config(MODE_IIR, 7'd65, 5'd17);
    send_req(FUNC_CLEAR, rand_word(), 6'($urandom), rand_word());
    send_sample(SMP_MAX);

    // randomized streams over a spread of settings
    run_phase(100, MODE_FIR, 7'd4,   5'd15);
    run_phase(100, MODE_IIR, 7'd3,   5'd14);
    run_phase(100, MODE_FIR, 7'd8,   5'd0);
    run_phase(100, MODE_IIR, 7'd2,   5'd31);
    run_phase(60,  MODE_FIR, 7'd64,  5'd20);
    run_phase(60,  MODE_IIR, 7'd64,  5'd15);
    run_phase(60,  MODE_FIR, 7'd0,   5'd5);
    run_phase(60,  MODE_IIR, 7'd100, 5'd10);
    repeat (3) run_phase(140, 1'($urandom), 7'($urandom_range(1, 16)), 5'($urandom));
    // last stretch runs with both sides at full rate
    gaps_on <= 1'b0;
    run_phase(140, 1'($urandom), 7'($urandom_range(1, 16)), 5'($urandom));

    wait_idle(1'b1);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
